FILE: hw/rtl/tgad_pkg.sv
// Shared types and constants of the TGA truecolor stream decoder.
package tgad_pkg;

  localparam logic [4:0]  HDR_LAST_IDX     = 5'd17;
  localparam logic [4:0]  IDX_ID_LEN       = 5'd0;
  localparam logic [4:0]  IDX_IMG_TYPE     = 5'd2;
  localparam logic [4:0]  IDX_WIDTH_LO     = 5'd12;
  localparam logic [4:0]  IDX_WIDTH_HI     = 5'd13;
  localparam logic [4:0]  IDX_HEIGHT_LO    = 5'd14;
  localparam logic [4:0]  IDX_HEIGHT_HI    = 5'd15;
  localparam logic [4:0]  IDX_DEPTH        = 5'd16;
  localparam logic [7:0]  TYPE_TRUECOLOR   = 8'd2;
  localparam int unsigned TOP_ORIGIN_BIT   = 5;
  localparam logic [7:0]  DEPTH_RGB        = 8'd24;
  localparam logic [7:0]  DEPTH_RGBA       = 8'd32;
  localparam logic [31:0] MAX_PIXELS_RESET = 32'd67108864;
  localparam logic [2:0]  CH_RGB           = 3'd3;
  localparam logic [2:0]  CH_RGBA          = 3'd4;
  localparam int unsigned QUEUE_DEPTH      = 4;
  localparam int unsigned TDATA_W          = 104;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_TYPE  = 2'd0,
    ERR_SIZE  = 2'd1,
    ERR_COUNT = 2'd2,
    ERR_TRUNC = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HEADER = 3'd1,
    PH_IDSKIP = 3'd2,
    PH_PIXELS = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  // Parser state of one file.
  typedef struct packed {
    phase_e      phase;
    logic [4:0]  idx;
    logic [7:0]  id_left;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  img_type;
    logic [7:0]  depth;
    logic        has_alpha;
    logic        top_first;
    logic [23:0] partial;
    logic [1:0]  bop;
    logic [15:0] col;
    logic [15:0] srow;
    logic [31:0] area;
  } fstate_t;

  // One classified result between front and back.
  typedef struct packed {
    kind_e       kind;
    err_e        err;
    logic [15:0] width;
    logic [15:0] height;
    logic        has_alpha;
    logic [15:0] column;
    logic [15:0] srow;
    logic        top_first;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        fin;
  } entry_t;

  // Finished output word.
  typedef struct packed {
    kind_e       kind;
    err_e        err;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  ccount;
    logic [15:0] column;
    logic [15:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        fin;
  } out_t;

endpackage

FILE: hw/rtl/tga_truecolor_stream_decoder.sv
// Top level of the TGA truecolor stream decoder.
//
// Input stream: one file byte per word. tdata[7:0] is the byte, tuser flags
// the first header byte of a new file (parsing restarts there from any
// state), tlast flags the last byte the source sends for that file.
// Output stream: at most one word per input byte. tuser is the kind (header
// accepted, pixel, error), tlast marks the final pixel of the image, tdata
// carries error code, size, channel count, column, top-down row and RGBA.
// The user writes the max_pixels register via cfg_we_i/cfg_wdata_i only while
// the block is idle, unchecked by the block; larger images end in an error word.
//
// Throughput: one byte per cycle while the queue has room. The parser updates
// its counters in the cycle a byte is accepted and writes any result into a
// four-word queue at that same edge; the output register loads the queue head
// once it is empty or its word is taken, and m_axis_tvalid rises as it loads.
// s_axis_tready drops only when the queue is full, so a stalled receiver backs
// up the queue before the input is held.
// Reset clears the parser to idle, empties the queue and the output
// register, and sets max_pixels to 64 Mi pixels.
module tga_truecolor_stream_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] file_byte
  input  logic                          s_axis_tuser,   // [0] start_of_file
  input  logic                          s_axis_tlast,   // last_byte
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] error_code, [17:2] image_width, [33:18] image_height,
  // [36:34] channel_count, [52:37] column, [68:53] row, [76:69] red,
  // [84:77] green, [92:85] blue, [100:93] alpha, [103:101] zero
  output logic [tgad_pkg::TDATA_W-1:0]  m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,   // [1:0] kind
  output logic                          m_axis_tlast    // final_pixel
);

  logic             in_fire;
  logic             push, pop, q_full, q_valid;
  tgad_pkg::entry_t entry, head;
  tgad_pkg::out_t   word;

  // accept only when a result of this byte is sure to find a queue slot
  assign s_axis_tready = !q_full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  tgad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_fire_i   (in_fire),
    .byte_i      (s_axis_tdata),
    .sof_i       (s_axis_tuser),
    .last_i      (s_axis_tlast),
    .push_o      (push),
    .entry_o     (entry)
  );

  tgad_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (entry),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  tgad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (head),
    .q_pop_o     (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_o       (word)
  );

  // pack the output word, highest field first
  assign m_axis_tdata = {3'd0, word.alpha, word.blue, word.green, word.red, word.row,
                         word.column, word.ccount, word.height, word.width, word.err};
  assign m_axis_tuser = word.kind;
  assign m_axis_tlast = word.fin;

endmodule

FILE: hw/rtl/tgad_front.sv
// Byte parser: header capture and checks, id skip, pixel assembly.
module tgad_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              in_fire_i,
  input  logic [7:0]        byte_i,
  input  logic              sof_i,
  input  logic              last_i,
  output logic              push_o,
  output tgad_pkg::entry_t  entry_o
);

  tgad_pkg::fstate_t st_q, st_d;
  logic [31:0] max_pixels_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= '0;
      max_pixels_q <= tgad_pkg::MAX_PIXELS_RESET;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        max_pixels_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    tgad_pkg::fstate_t cur;
    logic [1:0]  lastb;
    logic        fin;
    cur     = st_q;
    st_d    = st_q;
    push_o  = 1'b0;
    entry_o = '0;
    lastb   = 2'd2;
    fin     = 1'b0;
    if (in_fire_i) begin
      // a start marker restarts parsing from any phase
      if (sof_i) begin
        cur       = '0;
        cur.phase = tgad_pkg::PH_HEADER;
      end
      st_d = cur;
      unique case (cur.phase)
        tgad_pkg::PH_HEADER: begin
          unique case (cur.idx)
            tgad_pkg::IDX_ID_LEN:    st_d.id_left = byte_i;
            tgad_pkg::IDX_IMG_TYPE:  st_d.img_type = byte_i;
            tgad_pkg::IDX_WIDTH_LO:  st_d.width[7:0] = byte_i;
            tgad_pkg::IDX_WIDTH_HI:  st_d.width[15:8] = byte_i;
            tgad_pkg::IDX_HEIGHT_LO: st_d.height[7:0] = byte_i;
            tgad_pkg::IDX_HEIGHT_HI: st_d.height[15:8] = byte_i;
            tgad_pkg::IDX_DEPTH: begin
              st_d.depth     = byte_i;
              st_d.has_alpha = (byte_i == tgad_pkg::DEPTH_RGBA);
              // size is complete here: precompute the area for the last byte
              st_d.area      = {16'd0, cur.width} * {16'd0, cur.height};
            end
            tgad_pkg::HDR_LAST_IDX:  st_d.top_first = byte_i[tgad_pkg::TOP_ORIGIN_BIT];
            default: ;
          endcase
          if (cur.idx != tgad_pkg::HDR_LAST_IDX) begin
            st_d.idx = cur.idx + 5'd1;
            if (last_i) begin
              push_o        = 1'b1;
              entry_o.kind  = tgad_pkg::KIND_ERROR;
              entry_o.err   = tgad_pkg::ERR_TRUNC;
              st_d.phase    = tgad_pkg::PH_DONE;
            end
          end else begin
            push_o = 1'b1;
            if (cur.img_type != tgad_pkg::TYPE_TRUECOLOR) begin
              entry_o.kind = tgad_pkg::KIND_ERROR;
              entry_o.err  = tgad_pkg::ERR_TYPE;
              st_d.phase   = tgad_pkg::PH_DONE;
            end else if (cur.width == 16'd0 || cur.height == 16'd0 ||
                         (cur.depth != tgad_pkg::DEPTH_RGB &&
                          cur.depth != tgad_pkg::DEPTH_RGBA)) begin
              entry_o.kind = tgad_pkg::KIND_ERROR;
              entry_o.err  = tgad_pkg::ERR_SIZE;
              st_d.phase   = tgad_pkg::PH_DONE;
            end else if (cur.area > max_pixels_q) begin
              entry_o.kind = tgad_pkg::KIND_ERROR;
              entry_o.err  = tgad_pkg::ERR_COUNT;
              st_d.phase   = tgad_pkg::PH_DONE;
            end else if (last_i) begin
              entry_o.kind = tgad_pkg::KIND_ERROR;
              entry_o.err  = tgad_pkg::ERR_TRUNC;
              st_d.phase   = tgad_pkg::PH_DONE;
            end else begin
              entry_o.kind      = tgad_pkg::KIND_HEADER;
              entry_o.width     = cur.width;
              entry_o.height    = cur.height;
              entry_o.has_alpha = cur.has_alpha;
              st_d.phase = (cur.id_left != 8'd0) ? tgad_pkg::PH_IDSKIP
                                                 : tgad_pkg::PH_PIXELS;
            end
          end
        end
        tgad_pkg::PH_IDSKIP: begin
          st_d.id_left = cur.id_left - 8'd1;
          if (cur.id_left == 8'd1) begin
            st_d.phase = tgad_pkg::PH_PIXELS;
          end
          if (last_i) begin
            push_o       = 1'b1;
            entry_o.kind = tgad_pkg::KIND_ERROR;
            entry_o.err  = tgad_pkg::ERR_TRUNC;
            st_d.phase   = tgad_pkg::PH_DONE;
          end
        end
        tgad_pkg::PH_PIXELS: begin
          lastb = cur.has_alpha ? 2'd3 : 2'd2;
          if (cur.bop < lastb) begin
            case (cur.bop)
              2'd0:    st_d.partial[7:0]   = byte_i;
              2'd1:    st_d.partial[15:8]  = byte_i;
              default: st_d.partial[23:16] = byte_i;
            endcase
            st_d.bop = cur.bop + 2'd1;
            if (last_i) begin
              push_o       = 1'b1;
              entry_o.kind = tgad_pkg::KIND_ERROR;
              entry_o.err  = tgad_pkg::ERR_TRUNC;
              st_d.phase   = tgad_pkg::PH_DONE;
            end
          end else begin
            fin = ({1'b0, cur.srow} + 17'd1 == {1'b0, cur.height}) &&
                  ({1'b0, cur.col} + 17'd1 == {1'b0, cur.width});
            st_d.partial = '0;
            st_d.bop     = 2'd0;
            if ({1'b0, cur.col} + 17'd1 >= {1'b0, cur.width}) begin
              st_d.col  = 16'd0;
              st_d.srow = cur.srow + 16'd1;
            end else begin
              st_d.col  = cur.col + 16'd1;
            end
            push_o = 1'b1;
            if (!fin && last_i) begin
              entry_o.kind = tgad_pkg::KIND_ERROR;
              entry_o.err  = tgad_pkg::ERR_TRUNC;
              st_d.phase   = tgad_pkg::PH_DONE;
            end else begin
              if (fin) begin
                st_d.phase = tgad_pkg::PH_DONE;
              end
              entry_o.kind      = tgad_pkg::KIND_PIXEL;
              entry_o.width     = cur.width;
              entry_o.height    = cur.height;
              entry_o.has_alpha = cur.has_alpha;
              entry_o.column    = cur.col;
              entry_o.srow      = cur.srow;
              entry_o.top_first = cur.top_first;
              entry_o.blue      = cur.partial[7:0];
              entry_o.green     = cur.partial[15:8];
              entry_o.red       = cur.has_alpha ? cur.partial[23:16] : byte_i;
              entry_o.alpha     = cur.has_alpha ? byte_i : 8'd0;
              entry_o.fin       = fin;
            end
          end
        end
        default: ;  // idle or done: drop the byte
      endcase
    end
  end

endmodule

FILE: hw/rtl/tgad_queue.sv
// Short register queue of classified results between front and back.
module tgad_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tgad_pkg::entry_t  push_data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              valid_o,
  output tgad_pkg::entry_t  head_o
);

  localparam int unsigned PtrW = $clog2(tgad_pkg::QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(tgad_pkg::QUEUE_DEPTH + 1);

  tgad_pkg::entry_t slot_q [tgad_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(tgad_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/tgad_back.sv
// Output stage: row flip, channel count and the output word register.
module tgad_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  tgad_pkg::entry_t  q_head_i,
  output logic              q_pop_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output tgad_pkg::out_t    out_o
);

  logic           valid_q;
  tgad_pkg::out_t word_q, word_d;

  assign q_pop_o     = q_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_o       = word_q;

  always_comb begin
    word_d        = '0;
    word_d.kind   = q_head_i.kind;
    word_d.err    = q_head_i.err;
    word_d.width  = q_head_i.width;
    word_d.height = q_head_i.height;
    word_d.column = q_head_i.column;
    word_d.red    = q_head_i.red;
    word_d.green  = q_head_i.green;
    word_d.blue   = q_head_i.blue;
    word_d.alpha  = q_head_i.alpha;
    word_d.fin    = q_head_i.fin;
    if (q_head_i.kind != tgad_pkg::KIND_ERROR) begin
      word_d.ccount = q_head_i.has_alpha ? tgad_pkg::CH_RGBA : tgad_pkg::CH_RGB;
    end
    if (q_head_i.kind == tgad_pkg::KIND_PIXEL) begin
      // bottom-origin files store the last row first
      word_d.row = q_head_i.top_first ? q_head_i.srow
                                      : q_head_i.height - 16'd1 - q_head_i.srow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      word_q <= word_d;
    end
  end

endmodule

FILE: hw/rtl/tgad_checker.sv
// Port-level checker of the decoder output stream, bound to the top level.
module tgad_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [tgad_pkg::TDATA_W-1:0]  m_axis_tdata,
  input logic [1:0]                    m_axis_tuser,
  input logic                          m_axis_tlast
);

  // final pixel flag only rides on pixel words
  a_last_on_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == tgad_pkg::KIND_PIXEL)
    else $error("tlast on a non-pixel word");

  // error words carry nothing beyond the code
  a_error_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == tgad_pkg::KIND_ERROR |->
      m_axis_tdata[tgad_pkg::TDATA_W-1:2] == '0 && !m_axis_tlast)
    else $error("error word with payload");

  // header and pixel words report three or four channels
  a_channels : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != tgad_pkg::KIND_ERROR |->
      m_axis_tdata[36:34] == tgad_pkg::CH_RGB || m_axis_tdata[36:34] == tgad_pkg::CH_RGBA)
    else $error("bad channel count");

  // a stalled word holds
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled word changed");

endmodule

bind tga_truecolor_stream_decoder tgad_checker u_tgad_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: bench/tb_tga_truecolor_stream_decoder.sv
// Self-checking testbench of the TGA truecolor stream decoder: directed and random files.
module tb_tga_truecolor_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import tgad_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // One output word, split into its fields.
  typedef struct packed {
    kind_e       kind;
    err_e        err;
    logic [15:0] width;
    logic [15:0] height;
    logic [2:0]  ccount;
    logic [15:0] column;
    logic [15:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        fin;
  } tga_word_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [31:0]          cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;
  logic                 s_axis_tuser  = 1'b0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  tga_truecolor_stream_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Traffic shaping knobs; idle and stall rates are percent of cycles.
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned stall_hold     = 0;   // cycles of forced receiver hold-off

  int unsigned bytes_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned header_words   = 0;
  int unsigned pixel_words    = 0;
  int unsigned error_words    = 0;
  int unsigned limit_settings = 0;

  tga_word_t expected_words[$];

  // Decoder shadow state.
  phase_e      dec_phase   = PH_IDLE;
  logic [4:0]  hdr_idx     = '0;
  logic [7:0]  id_left     = '0;
  logic [15:0] img_w       = '0;
  logic [15:0] img_h       = '0;
  logic [7:0]  img_type    = '0;
  logic [7:0]  img_depth   = '0;
  logic        alpha_on    = 1'b0;
  logic        top_down    = 1'b0;
  logic [23:0] pix_acc     = '0;
  logic [1:0]  pix_byte    = '0;
  logic [15:0] col_cnt     = '0;
  logic [15:0] srow_cnt    = '0;
  logic [31:0] pixel_limit = MAX_PIXELS_RESET;

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  // ------------------------------------------------------------------
  // Shadow decoder
  // ------------------------------------------------------------------

  // End the file with an error word.
  function automatic bit end_with_error(input err_e code, output tga_word_t w);
    w        = '0;
    w.kind   = KIND_ERROR;
    w.err    = code;
    dec_phase = PH_DONE;
    return 1'b1;
  endfunction

  function automatic void fill_size(inout tga_word_t w);
    w.width  = img_w;
    w.height = img_h;
    w.ccount = alpha_on ? CH_RGBA : CH_RGB;
  endfunction

  // Advance the shadow decoder by one file byte; return 1 when a word results.
  function automatic bit decode_byte(input logic [7:0] b, input logic sof,
                                     input logic last, output tga_word_t w);
    logic [63:0] area;
    logic [1:0]  final_idx;
    logic [15:0] col;
    logic [15:0] srow;
    logic        fin;
    w = '0;
    if (sof) begin
      // Restart from any phase and forget the previous file.
      dec_phase = PH_HEADER;
      hdr_idx   = '0;
      id_left   = '0;
      img_w     = '0;
      img_h     = '0;
      img_type  = '0;
      img_depth = '0;
      alpha_on  = 1'b0;
      top_down  = 1'b0;
      pix_acc   = '0;
      pix_byte  = '0;
      col_cnt   = '0;
      srow_cnt  = '0;
    end
    case (dec_phase)
      PH_HEADER: begin
        case (hdr_idx)
          IDX_ID_LEN:    id_left = b;
          IDX_IMG_TYPE:  img_type = b;
          IDX_WIDTH_LO:  img_w[7:0] = b;
          IDX_WIDTH_HI:  img_w[15:8] = b;
          IDX_HEIGHT_LO: img_h[7:0] = b;
          IDX_HEIGHT_HI: img_h[15:8] = b;
          IDX_DEPTH: begin
            img_depth = b;
            alpha_on  = (b == DEPTH_RGBA);
          end
          HDR_LAST_IDX:  top_down = b[TOP_ORIGIN_BIT];
          default: ;
        endcase
        if (hdr_idx != HDR_LAST_IDX) begin
          hdr_idx = hdr_idx + 5'd1;
          if (last) return end_with_error(ERR_TRUNC, w);
          return 1'b0;
        end
        // Checks in fixed order: type, then size and depth, then pixel count, then last flag.
        area = 64'(img_w) * 64'(img_h);
        if (img_type != TYPE_TRUECOLOR) return end_with_error(ERR_TYPE, w);
        if (img_w == 16'd0 || img_h == 16'd0 ||
            (img_depth != DEPTH_RGB && img_depth != DEPTH_RGBA))
          return end_with_error(ERR_SIZE, w);
        if (area > 64'(pixel_limit)) return end_with_error(ERR_COUNT, w);
        if (last) return end_with_error(ERR_TRUNC, w);
        dec_phase = (id_left != 8'd0) ? PH_IDSKIP : PH_PIXELS;
        w.kind = KIND_HEADER;
        fill_size(w);
        return 1'b1;
      end
      PH_IDSKIP: begin
        id_left = id_left - 8'd1;
        if (id_left == 8'd0) dec_phase = PH_PIXELS;
        if (last) return end_with_error(ERR_TRUNC, w);
        return 1'b0;
      end
      PH_PIXELS: begin
        final_idx = alpha_on ? 2'd3 : 2'd2;
        if (pix_byte < final_idx) begin
          pix_acc  = pix_acc | (24'(b) << (8 * pix_byte));
          pix_byte = pix_byte + 2'd1;
          if (last) return end_with_error(ERR_TRUNC, w);
          return 1'b0;
        end
        // Stored order is B, G, R (, A).
        col  = col_cnt;
        srow = srow_cnt;
        fin  = ({1'b0, srow} + 17'd1 == {1'b0, img_h}) &&
               ({1'b0, col} + 17'd1 == {1'b0, img_w});
        w.kind   = KIND_PIXEL;
        fill_size(w);
        w.column = col;
        w.row    = top_down ? srow : img_h - 16'd1 - srow;
        w.blue   = pix_acc[7:0];
        w.green  = pix_acc[15:8];
        w.red    = alpha_on ? pix_acc[23:16] : b;
        w.alpha  = alpha_on ? b : 8'd0;
        w.fin    = fin;
        pix_acc  = '0;
        pix_byte = '0;
        if ({1'b0, col} + 17'd1 >= {1'b0, img_w}) begin
          col_cnt  = '0;
          srow_cnt = srow + 16'd1;
        end else begin
          col_cnt = col + 16'd1;
        end
        // The final pixel wins over a last flag on the same byte.
        if (fin) dec_phase = PH_DONE;
        else if (last) return end_with_error(ERR_TRUNC, w);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Predict on every accepted input word, compare every accepted output word.
  always @(posedge clk_i) begin : scoreboard
    tga_word_t want;
    tga_word_t got;
    if (rst_ni) begin
      if (cfg_we_i) pixel_limit = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        if (decode_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast, want))
          expected_words.push_back(want);
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind   = kind_e'(m_axis_tuser);
        got.err    = err_e'(m_axis_tdata[1:0]);
        got.width  = m_axis_tdata[17:2];
        got.height = m_axis_tdata[33:18];
        got.ccount = m_axis_tdata[36:34];
        got.column = m_axis_tdata[52:37];
        got.row    = m_axis_tdata[68:53];
        got.red    = m_axis_tdata[76:69];
        got.green  = m_axis_tdata[84:77];
        got.blue   = m_axis_tdata[92:85];
        got.alpha  = m_axis_tdata[100:93];
        got.fin    = m_axis_tlast;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word, kind %0d", m_axis_tuser));
        end else begin
          want = expected_words.pop_front();
          check_field("kind", got.kind, want.kind);
          check_field("error_code", got.err, want.err);
          check_field("image_width", got.width, want.width);
          check_field("image_height", got.height, want.height);
          check_field("channel_count", got.ccount, want.ccount);
          check_field("column", got.column, want.column);
          check_field("row", got.row, want.row);
          check_field("red", got.red, want.red);
          check_field("green", got.green, want.green);
          check_field("blue", got.blue, want.blue);
          check_field("alpha", got.alpha, want.alpha);
          check_field("final_pixel", got.fin, want.fin);
          check_field("tdata pad", m_axis_tdata[103:101], 32'd0);
          case (want.kind)
            KIND_HEADER: header_words++;
            KIND_PIXEL:  pixel_words++;
            default:     error_words++;
          endcase
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Receiver: random stalls, plus a counted hold-off on request
  // ------------------------------------------------------------------

  initial begin : sink_ready
    forever begin
      @(posedge clk_i);
      if (stall_hold != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall_hold) @(posedge clk_i);
        stall_hold = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ------------------------------------------------------------------
  // Sender and file builders
  // ------------------------------------------------------------------

  // Offer one byte word after a random gap; return once it is accepted.
  task automatic send_byte(input logic [7:0] b, input logic sof, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= sof;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Send the first count bytes of a file; flag the first as start of file.
  task automatic send_stream(input byte_q_t q, input int count, input bit mark_last);
    for (int i = 0; i < count; i++)
      send_byte(q[i], i == 0, mark_last && (i == count - 1));
  endtask

  // Hold the input until every expected word has arrived, then let the pipe settle.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_max_pixels(input logic [31:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    limit_settings++;
  endtask

  function automatic byte_q_t random_bytes(input int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom));
    return q;
  endfunction

  // 18-byte header followed by the image-id field.
  function automatic byte_q_t tga_header(input logic [7:0] itype, input logic [15:0] w,
                                         input logic [15:0] h, input logic [7:0] depth,
                                         input logic [7:0] desc, input logic [7:0] id_len);
    byte_q_t q;
    q.push_back(id_len);
    q.push_back(8'($urandom));
    q.push_back(itype);
    repeat (9) q.push_back(8'($urandom));   // color map spec and origin
    q.push_back(w[7:0]);
    q.push_back(w[15:8]);
    q.push_back(h[7:0]);
    q.push_back(h[15:8]);
    q.push_back(depth);
    q.push_back(desc);
    repeat (id_len) q.push_back(8'($urandom));
    return q;
  endfunction

  // Well-formed file with random pixel content.
  function automatic byte_q_t tga_file(input logic [15:0] w, input logic [15:0] h,
                                       input logic [7:0] depth, input logic [7:0] desc,
                                       input logic [7:0] id_len);
    int n;
    n = int'(w) * int'(h) * ((depth == DEPTH_RGBA) ? 4 : 3);
    return {tga_header(TYPE_TRUECOLOR, w, h, depth, desc, id_len), random_bytes(n)};
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Bytes before any start of file produce nothing.
  task automatic test_idle_noise();
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  // Each header check, the check order, and bytes ignored after an error.
  task automatic test_header_checks();
    byte_q_t f;
    // Wrong type together with zero size, last on byte 17: type error wins.
    f = tga_header(8'd10, 16'd0, 16'd0, 8'd16, 8'h00, 8'd0);
    send_stream(f, f.size(), 1'b1);
    f = tga_header(TYPE_TRUECOLOR, 16'd0, 16'd3, DEPTH_RGB, 8'h00, 8'd0);
    send_stream({f, random_bytes(4)}, f.size() + 4, 1'b1);
    f = tga_header(TYPE_TRUECOLOR, 16'd3, 16'd0, DEPTH_RGBA, 8'h20, 8'd0);
    send_stream(f, f.size(), 1'b0);
    f = tga_header(TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd16, 8'h00, 8'd0);
    send_stream(f, f.size(), 1'b0);
    // Too many pixels against the reset limit, just over and far over.
    f = tga_header(TYPE_TRUECOLOR, 16'd8193, 16'd8192, DEPTH_RGB, 8'h00, 8'd0);
    send_stream(f, f.size(), 1'b0);
    f = tga_header(TYPE_TRUECOLOR, 16'hFFFF, 16'hFFFF, DEPTH_RGBA, 8'hFF, 8'd0);
    send_stream(f, f.size(), 1'b0);
    // Stray bytes after the error are dropped.
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  // Complete images: both origins, both depths, id skip, trailing bytes.
  task automatic test_small_images();
    byte_q_t f;
    // 2x1 RGB bottom origin with extreme channel values, last on final pixel.
    f = tga_header(TYPE_TRUECOLOR, 16'd2, 16'd1, DEPTH_RGB, 8'h00, 8'd0);
    for (int i = 0; i < 6; i++) f.push_back((i < 3) ? 8'hFF : 8'h00);
    send_stream(f, f.size(), 1'b1);
    f = tga_file(16'd1, 16'd2, DEPTH_RGBA, 8'h20, 8'd3);
    send_stream(f, f.size(), 1'b1);
    f = tga_file(16'd3, 16'd2, DEPTH_RGB, 8'hDF, 8'd0);
    f = {f, random_bytes(3)};
    send_stream(f, f.size(), 1'b1);
    f = tga_file(16'd2, 16'd2, DEPTH_RGBA, 8'hFF, 8'd0);
    send_stream(f, f.size(), 1'b0);
    // Longest image-id field.
    f = tga_file(16'd1, 16'd1, DEPTH_RGB, 8'h00, 8'd255);
    send_stream(f, f.size(), 1'b1);
    wait_results_drained();
  endtask

  // Last flag at every stage of a file, and restarts in mid-file.
  task automatic test_truncation();
    byte_q_t f;
    f = tga_file(16'd2, 16'd1, DEPTH_RGB, 8'h00, 8'd0);
    send_stream(f, 1, 1'b1);                // start and last on one byte
    send_stream(f, 6, 1'b1);                // inside the header
    send_stream(f, 18, 1'b1);               // on the final byte of a good header
    send_stream(f, 20, 1'b1);               // inside a pixel
    send_stream(f, 21, 1'b1);               // completing a non-final pixel
    f = tga_file(16'd1, 16'd1, DEPTH_RGBA, 8'h20, 8'd2);
    send_stream(f, 19, 1'b1);               // during the id skip
    f = tga_file(16'd3, 16'd2, DEPTH_RGBA, 8'h00, 8'd0);
    send_stream(f, 25, 1'b0);               // drop it for a new file
    f = tga_file(16'd2, 16'd2, DEPTH_RGB, 8'h20, 8'd0);
    send_stream(f, 10, 1'b0);               // restart inside a header
    send_stream(f, f.size(), 1'b1);
    wait_results_drained();
  endtask

  // Widest and tallest images, cut short after a few pixels.
  task automatic test_wide_images();
    byte_q_t f;
    f = {tga_header(TYPE_TRUECOLOR, 16'hFFFF, 16'd1, DEPTH_RGB, 8'h20, 8'd0),
         random_bytes(6)};
    send_stream(f, f.size(), 1'b1);
    wait_results_drained();
    write_max_pixels(32'hFFFE_0001);
    // Area equals the limit; bottom origin puts the first row at 65534.
    f = {tga_header(TYPE_TRUECOLOR, 16'hFFFF, 16'hFFFF, DEPTH_RGBA, 8'h00, 8'd0),
         random_bytes(9)};
    send_stream(f, f.size(), 1'b1);
    wait_results_drained();
  endtask

  // Pixel limit at its low end and at an exact boundary.
  task automatic test_pixel_limit();
    byte_q_t f;
    write_max_pixels(32'd1);
    f = tga_file(16'd1, 16'd1, DEPTH_RGB, 8'h00, 8'd0);
    send_stream(f, f.size(), 1'b1);
    f = tga_file(16'd2, 16'd1, DEPTH_RGB, 8'h00, 8'd0);
    send_stream(f, f.size(), 1'b1);
    wait_results_drained();
    write_max_pixels(32'd6);
    f = tga_file(16'd3, 16'd2, DEPTH_RGBA, 8'h20, 8'd1);
    send_stream(f, f.size(), 1'b1);
    f = tga_file(16'd2, 16'd4, DEPTH_RGB, 8'h00, 8'd0);
    send_stream(f, f.size(), 1'b1);
    wait_results_drained();
    write_max_pixels(MAX_PIXELS_RESET);
  endtask

  // Long receiver hold-off fills the result queue; then pause mid-file.
  task automatic test_backpressure();
    byte_q_t f;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    stall_hold     = 150;
    f = tga_file(16'd4, 16'd4, DEPTH_RGBA, 8'h20, 8'd0);
    send_stream(f, f.size(), 1'b1);
    f = tga_file(16'd3, 16'd3, DEPTH_RGB, 8'h00, 8'd0);
    for (int i = 0; i < f.size(); i++) begin
      send_byte(f[i], i == 0, i == f.size() - 1);
      if (i == 30) wait_results_drained();  // stop offering until all words are out
    end
    wait_results_drained();
  endtask

  // Random files: mostly well formed, some cut, broken or noise.
  task automatic random_traffic(input int unsigned n_bytes);
    byte_q_t     f;
    int unsigned stop_at;
    int unsigned pick;
    logic [15:0] w;
    logic [15:0] h;
    logic [7:0]  depth;
    logic [7:0]  id_len;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick   = $urandom_range(99);
      w      = 16'($urandom_range(1, 5));
      h      = 16'($urandom_range(1, 4));
      depth  = $urandom_range(1) ? DEPTH_RGBA : DEPTH_RGB;
      id_len = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 4)) : 8'd0;
      f      = tga_file(w, h, depth, 8'($urandom), id_len);
      if (pick < 60) begin
        if ($urandom_range(4) == 0) f = {f, random_bytes($urandom_range(1, 3))};
        send_stream(f, f.size(), 1'b1);
      end else if (pick < 72) begin
        send_stream(f, $urandom_range(1, f.size() - 1), 1'b1);
      end else if (pick < 80) begin
        send_stream(f, $urandom_range(1, f.size() - 1), 1'b0);
      end else if (pick < 90) begin
        // Broken or oversized header.
        case ($urandom_range(3))
          0: f = tga_header(8'($urandom), w, h, depth, 8'($urandom), 8'd0);
          1: f = tga_header(TYPE_TRUECOLOR, $urandom_range(1) ? 16'd0 : w,
                            $urandom_range(1) ? 16'd0 : h, depth, 8'($urandom), 8'd0);
          2: f = tga_header(TYPE_TRUECOLOR, w, h, 8'($urandom), 8'($urandom), 8'd0);
          default: f = tga_header(TYPE_TRUECOLOR, 16'($urandom), 16'($urandom),
                                  depth, 8'($urandom), id_len);
        endcase
        f = {f, random_bytes($urandom_range(0, 8))};
        send_stream(f, f.size(), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom), $urandom_range(7) == 0, $urandom_range(3) == 0);
      end
    end
  endtask

  // Random traffic under each idling pattern and limit setting.
  task automatic test_random_phases();
    wait_results_drained();
    write_max_pixels(MAX_PIXELS_RESET);
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    random_traffic(180);
    wait_results_drained();
    write_max_pixels(32'($urandom_range(4, 12)));
    src_idle_pct   = 82;
    sink_stall_pct = 0;
    random_traffic(180);
    wait_results_drained();
    write_max_pixels(32'hFFFE_0001);
    src_idle_pct   = 0;
    sink_stall_pct = 82;
    random_traffic(180);
    wait_results_drained();
    write_max_pixels(32'd20);
    src_idle_pct   = 6;
    sink_stall_pct = 6;
    random_traffic(180);
    wait_results_drained();
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------

  initial begin : run
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_noise();
    test_header_checks();
    test_small_images();
    test_truncation();
    test_wide_images();
    test_pixel_limit();
    test_backpressure();
    test_random_phases();
    repeat (20) @(posedge clk_i);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d expected words never arrived", expected_words.size()));
    $display("Sent %0d file bytes over %0d pixel limit settings and four idling patterns;",
             bytes_sent, limit_settings);
    $display("checked %0d header, %0d pixel and %0d error words.",
             header_words, pixel_words, error_words);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
